// File: rtl/core/sled_pkg.sv
`timescale 1ns / 1ps

package sled_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
  } out_item_t;

  // raw characters that steer the decode
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_LC_A   = 8'h61;
  localparam logic [7:0] CHR_LC_F   = 8'h66;
  localparam logic [7:0] CHR_UC_A   = 8'h41;
  localparam logic [7:0] CHR_UC_F   = 8'h46;
  localparam logic [7:0] CHR_LC_N   = 8'h6E;
  localparam logic [7:0] CHR_LC_R   = 8'h72;
  localparam logic [7:0] CHR_LC_T   = 8'h74;
  localparam logic [7:0] CHR_LC_X   = 8'h78;
  localparam logic [7:0] CHR_UC_X   = 8'h58;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;

  // decoded values of the simple escapes
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        d = c - CHR_ZERO;
      end else if (c >= CHR_LC_A && c <= CHR_LC_F) begin
        d = c - CHR_LC_A + 8'd10;
      end else if (c >= CHR_UC_A && c <= CHR_UC_F) begin
        d = c - CHR_UC_A + 8'd10;
      end
      return d[3:0];
    end
  endfunction

endpackage

// File: rtl/core/sled_decoder.sv
`timescale 1ns / 1ps

module sled_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  sled_pkg::in_item_t item,
  output logic               res_valid,
  output sled_pkg::out_item_t res
);
  import sled_pkg::*;

  typedef enum logic [1:0] {
    MODE_OPEN,
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       hex_phase_r, hex_phase_nxt;
  logic [3:0] hex_high_r, hex_high_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;

  logic       got;
  logic [7:0] dec_byte;

  always_comb begin
    mode_nxt      = mode_r;
    hex_phase_nxt = hex_phase_r;
    hex_high_nxt  = hex_high_r;
    got           = 1'b0;
    dec_byte      = 8'h00;

    unique case (mode_r)
      MODE_OPEN: begin
        mode_nxt = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (item.in_char == CHR_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          got      = 1'b1;
          dec_byte = item.in_char;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        unique case (item.in_char)
          CHR_BSLASH: begin got = 1'b1; dec_byte = CHR_BSLASH; end
          CHR_ZERO:   begin got = 1'b1; dec_byte = BYTE_NUL;   end
          CHR_LC_N:   begin got = 1'b1; dec_byte = BYTE_LF;    end
          CHR_LC_R:   begin got = 1'b1; dec_byte = BYTE_CR;    end
          CHR_LC_F:   begin got = 1'b1; dec_byte = BYTE_FF;    end
          CHR_LC_T:   begin got = 1'b1; dec_byte = BYTE_TAB;   end
          CHR_QUOTE:  begin got = 1'b1; dec_byte = CHR_QUOTE;  end
          CHR_LC_X, CHR_UC_X: begin
            mode_nxt      = MODE_HEX;
            hex_phase_nxt = 1'b0;
          end
          default: begin
            // unknown escape yields nothing
          end
        endcase
      end
      MODE_HEX: begin
        if (!hex_phase_r) begin
          hex_high_nxt  = hex_value(item.in_char);
          hex_phase_nxt = 1'b1;
        end else begin
          hex_phase_nxt = 1'b0;
          mode_nxt      = MODE_TEXT;
          got           = 1'b1;
          dec_byte      = {hex_high_r, hex_value(item.in_char)};
        end
      end
      default: begin
        mode_nxt = MODE_OPEN;
      end
    endcase

    held_byte_nxt  = got ? dec_byte : held_byte_r;
    held_valid_nxt = held_valid_r | got;

    if (item.last) begin
      res_valid         = 1'b1;
      res.out_byte      = held_valid_r ? held_byte_r : 8'h00;
      res.byte_valid    = held_valid_r;
      res.end_of_string = 1'b1;
      mode_nxt          = MODE_OPEN;
      hex_phase_nxt     = 1'b0;
      hex_high_nxt      = 4'h0;
      held_byte_nxt     = 8'h00;
      held_valid_nxt    = 1'b0;
    end else begin
      res_valid         = got & held_valid_r;
      res.out_byte      = held_byte_r;
      res.byte_valid    = 1'b1;
      res.end_of_string = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OPEN;
      hex_phase_r  <= 1'b0;
      hex_high_r   <= 4'h0;
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      hex_phase_r  <= hex_phase_nxt;
      hex_high_r   <= hex_high_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

// File: rtl/core/string_literal_escape_decoder_unit.sv
`timescale 1ns / 1ps

// String literal escape decoder. Raw characters of a quoted literal arrive one
// item per cycle while in_stall is low, opening quote first, with last set on
// the closing quote. The opening character is dropped, the escapes \\ \0 \n \r
// \f \t \" and \xHH (or \XHH, a non-hex digit counting as zero) are decoded,
// and an unknown escape gives nothing. Each decoded byte waits in a one-byte
// hold and is sent only when the next decoded byte arrives or the literal closes,
// so the closing quote never leaves. The item carrying last always gives one
// result with end_of_string set, carrying the held byte if there is one.
// Throughput is one item per cycle while the output is not stalled: the input
// register feeds the decode logic, which writes the output register in the
// same cycle. in_stall rises only while the input register is full and the
// output register is full and stalled.

module string_literal_escape_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sled_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sled_pkg::out_item_t out_item
);
  import sled_pkg::*;

  // input register
  logic      in_vld_r;
  in_item_t  in_item_r;

  // output register
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  // the held item moves into decode when the output side has room
  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;

  sled_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // a stalled result holds; an item with no result leaves the register empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_valid;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // input side only stalls behind a stalled full output
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // a closing item always yields a result in the next cycle
  a_last_gives_end : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_item_r.last && advance) |=> (out_valid && out_item.end_of_string))
    else $error("closing item gave no end-of-string result");

  // results other than the closing one always carry a byte
  a_mid_has_byte : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.end_of_string) |-> out_item.byte_valid)
    else $error("non-final result without a byte");

  // an empty closing result carries a zero byte
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.byte_valid) |-> (out_item.out_byte == 8'h00))
    else $error("empty result with non-zero byte");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sled_pkg::*;

  // a whole literal plus the longest hold-off fits many times over
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 10;

  // where the decoder stands within a literal
  typedef enum logic [1:0] {
    MODE_OPEN,
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX
  } dec_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // shadow of the decoder state
  dec_mode_t  mode_q = MODE_OPEN;
  logic       hex_lo_next = 1'b0;
  logic [3:0] hex_hi = 4'h0;
  logic [7:0] hold_byte = 8'h00;
  logic       hold_full = 1'b0;

  out_item_t decoded_q[$];

  int  gap_pct = 0;
  int  stall_pct = 0;
  int  items_sent = 0;
  int  fails = 0;
  int  quiet_cycles = 0;
  bit  hold_req = 1'b0;

  string_literal_escape_decoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // value of one hex digit, anything else reads as zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= CHR_ZERO && c <= CHR_NINE) v = c - CHR_ZERO;
    if (c >= CHR_LC_A && c <= CHR_LC_F) v = c - CHR_LC_A + 8'd10;
    if (c >= CHR_UC_A && c <= CHR_UC_F) v = c - CHR_UC_A + 8'd10;
    return v[3:0];
  endfunction

  // advance the shadow decoder by one accepted character and queue
  // whatever result it should produce
  function automatic void decode_expect(input in_item_t it);
    logic       got;
    logic [7:0] b;
    logic [7:0] prev_byte;
    logic       prev_full;
    out_item_t  r;
    got = 1'b0;
    b = 8'h00;
    prev_byte = hold_byte;
    prev_full = hold_full;
    case (mode_q)
      MODE_OPEN: begin
        // opener is dropped whatever it is
        mode_q = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (it.in_char == CHR_BSLASH) begin
          mode_q = MODE_ESC;
        end else begin
          got = 1'b1;
          b = it.in_char;
        end
      end
      MODE_ESC: begin
        mode_q = MODE_TEXT;
        got = 1'b1;
        case (it.in_char)
          CHR_BSLASH: b = CHR_BSLASH;
          CHR_ZERO:   b = BYTE_NUL;
          CHR_LC_N:   b = BYTE_LF;
          CHR_LC_R:   b = BYTE_CR;
          CHR_LC_F:   b = BYTE_FF;
          CHR_LC_T:   b = BYTE_TAB;
          CHR_QUOTE:  b = CHR_QUOTE;
          CHR_LC_X, CHR_UC_X: begin
            got = 1'b0;
            mode_q = MODE_HEX;
            hex_lo_next = 1'b0;
          end
          default: got = 1'b0;
        endcase
      end
      default: begin
        if (!hex_lo_next) begin
          hex_hi = digit_of(it.in_char);
          hex_lo_next = 1'b1;
        end else begin
          hex_lo_next = 1'b0;
          mode_q = MODE_TEXT;
          got = 1'b1;
          b = {hex_hi, digit_of(it.in_char)};
        end
      end
    endcase
    if (got) begin
      hold_byte = b;
      hold_full = 1'b1;
    end
    if (it.last) begin
      // closing item: flush the earlier held byte, the new one is lost
      r.out_byte = prev_full ? prev_byte : 8'h00;
      r.byte_valid = prev_full;
      r.end_of_string = 1'b1;
      decoded_q.push_back(r);
      mode_q = MODE_OPEN;
      hex_lo_next = 1'b0;
      hex_hi = 4'h0;
      hold_byte = 8'h00;
      hold_full = 1'b0;
    end else if (got && prev_full) begin
      r.out_byte = prev_byte;
      r.byte_valid = 1'b1;
      r.end_of_string = 1'b0;
      decoded_q.push_back(r);
    end
  endfunction

  // every accepted character feeds the shadow decoder
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) decode_expect(in_item);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, out_item);
        fails++;
      end else begin
        want = decoded_q.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
                   out_item.out_byte);
          fails++;
        end
        if (out_item.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid expected %b got %b", $time, want.byte_valid,
                   out_item.byte_valid);
          fails++;
        end
        if (out_item.end_of_string !== want.end_of_string) begin
          $display("%0t: end_of_string expected %b got %b", $time, want.end_of_string,
                   out_item.end_of_string);
          fails++;
        end
      end
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        for (n = 0; n < HOLDOFF_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // offer one character, with random gaps ahead of it, until it is taken
  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_char: c, last: is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255, 0));
  endfunction

  // mostly a proper hex digit, now and then any byte
  function automatic logic [7:0] rand_hex_digit();
    int k;
    k = $urandom_range(23, 0);
    if (k < 10) return 8'(CHR_ZERO + k);
    if (k < 16) return 8'(CHR_LC_A + (k - 10));
    if (k < 22) return 8'(CHR_UC_A + (k - 16));
    return rand_byte();
  endfunction

  // one piece of literal body: plain text or an escape of some kind
  task automatic send_piece();
    logic [7:0] e;
    case ($urandom_range(9, 0))
      5, 6: begin
        case ($urandom_range(6, 0))
          0: e = CHR_BSLASH;
          1: e = CHR_ZERO;
          2: e = CHR_LC_N;
          3: e = CHR_LC_R;
          4: e = CHR_LC_F;
          5: e = CHR_LC_T;
          default: e = CHR_QUOTE;
        endcase
        send_char(CHR_BSLASH, 1'b0);
        send_char(e, 1'b0);
      end
      7, 8: begin
        send_char(CHR_BSLASH, 1'b0);
        send_char($urandom_range(1, 0) ? CHR_LC_X : CHR_UC_X, 1'b0);
        send_char(rand_hex_digit(), 1'b0);
        send_char(rand_hex_digit(), 1'b0);
      end
      9: begin
        // unknown escapes, sometimes a known one by chance
        send_char(CHR_BSLASH, 1'b0);
        send_char(rand_byte(), 1'b0);
      end
      default: send_char(rand_byte(), 1'b0);
    endcase
  endtask

  // a literal: usually well formed, sometimes cut off inside an escape
  task automatic send_literal();
    logic [7:0] opener;
    int         n;
    opener = ($urandom_range(7, 0) == 0) ? rand_byte() : CHR_QUOTE;
    if ($urandom_range(15, 0) == 0) begin
      send_char(opener, 1'b1);
    end else begin
      send_char(opener, 1'b0);
      n = $urandom_range(10, 0);
      repeat (n) send_piece();
      if ($urandom_range(7, 0) == 0) begin
        send_char(CHR_BSLASH, 1'b0);
        if ($urandom_range(1, 0)) begin
          send_char(CHR_LC_X, 1'b0);
          if ($urandom_range(1, 0)) send_char(rand_hex_digit(), 1'b0);
        end
      end
      send_char(($urandom_range(7, 0) == 0) ? rand_byte() : CHR_QUOTE, 1'b1);
    end
  endtask

  // literals with a little raw noise mixed in, until n characters have gone
  task automatic run_literals(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(7, 0) == 0) begin
        repeat ($urandom_range(6, 1)) send_char(rand_byte(), $urandom_range(5, 0) == 0);
      end else begin
        send_literal();
      end
    end
  endtask

  task automatic test_directed();
    string body;
    int    i;
    gap_pct = 0;
    stall_pct = 0;
    // closing flag on the opening character
    send_char(CHR_QUOTE, 1'b1);
    // odd opener, every simple escape, upper and lower hex, an unknown escape,
    // a non-hex digit, and a NUL closing the literal inside a hex escape
    send_char(8'hFF, 1'b0);
    body = "\\\\\\0\\n\\r\\f\\t\\\"\\xFf\\q\\Xg";
    for (i = 0; i < body.len(); i++) send_char(body[i], 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_no_idling();
    gap_pct = 0;
    stall_pct = 0;
    run_literals(345);
  endtask

  task automatic test_sender_gaps();
    gap_pct = 69;
    stall_pct = 0;
    run_literals(345);
  endtask

  task automatic test_receiver_stalls();
    gap_pct = 0;
    stall_pct = 69;
    run_literals(345);
  endtask

  task automatic test_both_idle();
    gap_pct = 17;
    stall_pct = 17;
    run_literals(345);
  endtask

  // receiver holds off while items keep coming, so the input must back up
  task automatic test_long_holdoff();
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_literals(40);
    while (hold_req) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_idling();
    test_sender_gaps();
    test_long_holdoff();
    test_receiver_stalls();
    test_both_idle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
